// ----- rtl/e2r_pkg.sv -----
// Shared constants, types and helpers for the Euler-to-rotation-matrix block.
package e2r_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int NUM_STAGES   = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int STAGE_W      = $clog2(ATAN_ENTRIES);
   localparam int XY_W         = 34;
   localparam int Z_W          = 34;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

   typedef logic signed [XY_W-1:0] xy_type;
   typedef logic signed [Z_W-1:0]  z_type;
   typedef logic signed [15:0]     q14_type;

   // One angle's rotation state carried from cell to cell.
   typedef struct packed {
      xy_type x;
      xy_type y;
      z_type  z;
      logic   flip;
   } rot_type;

   typedef struct packed {
      rot_type yaw;
      rot_type pitch;
      rot_type roll;
   } cell_type;

   function automatic z_type atan_turns(input logic [STAGE_W-1:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10679838;
         5'd7:  v = 30'd5340245;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41721;
         5'd15: v = 30'd20860;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2607;
         5'd19: v = 30'd1303;
         5'd20: v = 30'd651;
         5'd21: v = 30'd325;
         5'd22: v = 30'd162;
         5'd23: v = 30'd81;
         default: v = 30'd0;
      endcase
      return z_type'({4'd0, v});
   endfunction

   function automatic q14_type clamp_unit(input logic signed [47:0] v);
      if (v > 48'sd16384)       return ONE_Q14;
      else if (v < -48'sd16384) return -ONE_Q14;
      else                      return v[15:0];
   endfunction

endpackage

// ----- rtl/e2r_cell.sv -----
// One CORDIC micro-rotation cell for all three angles, registered output.
module e2r_cell (
   input  logic                            clock,
   input  logic                            advance,
   input  logic [e2r_pkg::STAGE_W-1:0]     stage,
   input  e2r_pkg::cell_type               cell_in,
   output e2r_pkg::cell_type               cell_out
);
   import e2r_pkg::*;

   cell_type cell_ff, cell_in_w;

   function automatic rot_type step(input rot_type r, input logic [STAGE_W-1:0] i);
      rot_type o;
      xy_type dx, dy;
      z_type  a;
      o  = r;
      dx = r.y >>> i;
      dy = r.x >>> i;
      a  = atan_turns(i);
      if (!r.z[Z_W-1]) begin
         o.x = r.x - dx;
         o.y = r.y + dy;
         o.z = r.z - a;
      end else begin
         o.x = r.x + dx;
         o.y = r.y - dy;
         o.z = r.z + a;
      end
      return o;
   endfunction

   always_comb begin
      cell_in_w.yaw   = step(cell_in.yaw, stage);
      cell_in_w.pitch = step(cell_in.pitch, stage);
      cell_in_w.roll  = step(cell_in.roll, stage);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cell_ff <= cell_in_w;
      end
   end

   assign cell_out = cell_ff;
endmodule

// ----- rtl/e2r_matrix.sv -----
// Rounds CORDIC outputs and forms the nine matrix elements over three stages.
module e2r_matrix (
   input  logic                  clock,
   input  logic                  advance,
   input  e2r_pkg::cell_type     cell_in,
   output e2r_pkg::q14_type      m_out [9]
);
   import e2r_pkg::*;

   q14_type cy_ff, sy_ff, cp_ff, sp_ff, cr_ff, sr_ff;
   logic signed [31:0] p_ff [10];
   q14_type sp_d_ff, cy_d_ff, sy_d_ff;
   q14_type m_ff [9];
   logic signed [47:0] t01, t02, t11, t12;

   function automatic q14_type fin(input xy_type x, input logic flip);
      xy_type v;
      logic signed [XY_W-1:0] r;
      v = flip ? -x : x;
      r = (v + xy_type'(34'sd32768)) >>> 16;
      return clamp_unit(48'(r));
   endfunction

   function automatic q14_type rnd2(input logic signed [31:0] p);
      logic signed [31:0] r;
      r = (p + 32'sd8192) >>> 14;
      return clamp_unit(48'(r));
   endfunction

   function automatic q14_type rnd3(input logic signed [47:0] t);
      logic signed [47:0] r;
      r = (t + 48'sd134217728) >>> 28;
      return clamp_unit(r);
   endfunction

   // stage 1: sine/cosine
   always_ff @(posedge clock) begin
      if (advance) begin
         cy_ff <= fin(cell_in.yaw.x, cell_in.yaw.flip);
         sy_ff <= fin(cell_in.yaw.y, cell_in.yaw.flip);
         cp_ff <= fin(cell_in.pitch.x, cell_in.pitch.flip);
         sp_ff <= fin(cell_in.pitch.y, cell_in.pitch.flip);
         cr_ff <= fin(cell_in.roll.x, cell_in.roll.flip);
         sr_ff <= fin(cell_in.roll.y, cell_in.roll.flip);
      end
   end

   // stage 2: two-factor products
   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff[0] <= cp_ff * cy_ff;
         p_ff[1] <= cp_ff * sy_ff;
         p_ff[2] <= cp_ff * sr_ff;
         p_ff[3] <= cp_ff * cr_ff;
         p_ff[4] <= sp_ff * sr_ff;
         p_ff[5] <= cr_ff * sy_ff;
         p_ff[6] <= cr_ff * sp_ff;
         p_ff[7] <= sy_ff * sr_ff;
         p_ff[8] <= cr_ff * cy_ff;
         p_ff[9] <= cy_ff * sr_ff;
         sp_d_ff <= sp_ff;
         cy_d_ff <= cy_ff;
         sy_d_ff <= sy_ff;
      end
   end

   // stage 3: third factor, sum, round
   always_comb begin
      t01 = 48'(cy_d_ff) * 48'(p_ff[4]) - 48'(p_ff[5]) * 48'sd16384;
      t02 = 48'(cy_d_ff) * 48'(p_ff[6]) + 48'(p_ff[7]) * 48'sd16384;
      t11 = 48'(sy_d_ff) * 48'(p_ff[4]) + 48'(p_ff[8]) * 48'sd16384;
      t12 = 48'(sy_d_ff) * 48'(p_ff[6]) - 48'(p_ff[9]) * 48'sd16384;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_ff[0] <= rnd2(p_ff[0]);
         m_ff[1] <= rnd3(t01);
         m_ff[2] <= rnd3(t02);
         m_ff[3] <= rnd2(p_ff[1]);
         m_ff[4] <= rnd3(t11);
         m_ff[5] <= rnd3(t12);
         m_ff[6] <= clamp_unit(-48'(sp_d_ff));
         m_ff[7] <= rnd2(p_ff[2]);
         m_ff[8] <= rnd2(p_ff[3]);
      end
   end

   assign m_out = m_ff;
endmodule

// ----- rtl/euler_to_rotation_matrix.sv -----
// Top level: Z-Y-X Euler angles to rotation matrix, CORDIC cell chain plus product stages.
// Path from input beat to result beat: fold register, cell chain, then the matrix stages.
// Throughput: one triple per cycle; the whole pipe advances together and
// holds only when the result beat is stalled.
// Reset: synchronous, clears the valid bits of every stage; payload is not reset.
module euler_to_rotation_matrix (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_yaw_angle,
   input  logic signed [15:0] req_pitch_angle,
   input  logic signed [15:0] req_roll_angle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_m00,
   output logic signed [15:0] rsp_m01,
   output logic signed [15:0] rsp_m02,
   output logic signed [15:0] rsp_m10,
   output logic signed [15:0] rsp_m11,
   output logic signed [15:0] rsp_m12,
   output logic signed [15:0] rsp_m20,
   output logic signed [15:0] rsp_m21,
   output logic signed [15:0] rsp_m22
);
   import e2r_pkg::*;

   // fold register, one register per cell, three matrix stages
   localparam int DEPTH = NUM_STAGES + 4;

   logic [DEPTH-1:0] vld_ff, vld_in;
   logic advance;
   cell_type fold_ff, fold_in;
   cell_type chain [NUM_STAGES+1];
   q14_type m [9];

   // whole pipe moves unless the last beat is stuck
   assign advance   = !(vld_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !advance;

   function automatic rot_type fold(input logic [15:0] a);
      rot_type r;
      logic [31:0] ang;
      ang    = {a, 16'd0};
      r.flip = ang[31] ^ ang[30];
      if (r.flip) ang = ang - 32'h8000_0000;
      r.x = CORDIC_GAIN_Q30;
      r.y = '0;
      r.z = z_type'(signed'(ang));
      return r;
   endfunction

   always_comb begin
      fold_in.yaw   = fold(req_yaw_angle);
      fold_in.pitch = fold(req_pitch_angle);
      fold_in.roll  = fold(req_roll_angle);
      vld_in = {vld_ff[DEPTH-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fold_ff <= fold_in;
      end
   end

   assign chain[0] = fold_ff;

   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
      e2r_cell u_cell (
         .clock    (clock),
         .advance  (advance),
         .stage    (STAGE_W'(g)),
         .cell_in  (chain[g]),
         .cell_out (chain[g+1])
      );
   end

   e2r_matrix u_matrix (
      .clock   (clock),
      .advance (advance),
      .cell_in (chain[NUM_STAGES]),
      .m_out   (m)
   );

   assign rsp_valid = vld_ff[DEPTH-1];
   assign rsp_m00 = m[0];
   assign rsp_m01 = m[1];
   assign rsp_m02 = m[2];
   assign rsp_m10 = m[3];
   assign rsp_m11 = m[4];
   assign rsp_m12 = m[5];
   assign rsp_m20 = m[6];
   assign rsp_m21 = m[7];
   assign rsp_m22 = m[8];

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stuck result");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_m00) && $stable(rsp_m22))
      else $error("result changed while stalled");

   a_m20_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_m20 <= 16'sd16384) && (rsp_m20 >= -16'sd16384))
      else $error("element out of range");
endmodule

// ----- verif/euler_to_rotation_matrix_tb.sv -----
// Self-checking testbench for the Euler Z-Y-X to rotation matrix block.
module euler_to_rotation_matrix_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import e2r_pkg::*;

   localparam int RANDOM_BEATS = 1850;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int TAIL_CYCLES  = 60;

   typedef struct {
      logic signed [15:0] m [9];
   } matrix_type;

   function automatic longint saturate(longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
   endfunction

   // Round-half-up then arithmetic shift.
   function automatic longint round_q(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic void sincos(logic signed [15:0] a, output longint c, output longint s);
      logic [31:0] ang;
      longint x, y, z, dx, dy;
      longint atan_q [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                              21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                              333772, 166886, 83443, 41721, 20860, 10430, 5215,
                              2607, 1303, 651, 325, 162, 81};
      bit flip;
      ang = {a, 16'h0000};
      flip = ang[31] ^ ang[30];
      if (flip) ang = ang - 32'h8000_0000;
      z = longint'($signed(ang));
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_q[i];
         end else begin
            x += dx; y -= dy; z += atan_q[i];
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = saturate(round_q(x, 16));
      s = saturate(round_q(y, 16));
   endfunction

   function automatic matrix_type rotation_of(logic signed [15:0] yaw,
                                              logic signed [15:0] pitch,
                                              logic signed [15:0] roll);
      matrix_type r;
      longint cy, sy, cp, sp, cr, sr;
      sincos(yaw, cy, sy);
      sincos(pitch, cp, sp);
      sincos(roll, cr, sr);
      r.m[0] = 16'(saturate(round_q(cp * cy, 14)));
      r.m[1] = 16'(saturate(round_q(cy * sp * sr - cr * sy * 16384, 28)));
      r.m[2] = 16'(saturate(round_q(cr * cy * sp + sy * sr * 16384, 28)));
      r.m[3] = 16'(saturate(round_q(cp * sy, 14)));
      r.m[4] = 16'(saturate(round_q(sy * sp * sr + cr * cy * 16384, 28)));
      r.m[5] = 16'(saturate(round_q(sp * sy * cr - cy * sr * 16384, 28)));
      r.m[6] = 16'(saturate(-sp));
      r.m[7] = 16'(saturate(round_q(cp * sr, 14)));
      r.m[8] = 16'(saturate(round_q(cp * cr, 14)));
      return r;
   endfunction

   // Expected matrices in order; counts mismatches.
   class matrix_scoreboard;
      matrix_type pending [$];
      int         errors = 0;

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      function void note_angles(logic signed [15:0] yaw, logic signed [15:0] pitch,
                                logic signed [15:0] roll);
         pending.push_back(rotation_of(yaw, pitch, roll));
      endfunction

      task check_matrix(matrix_type got);
         matrix_type want;
         if (pending.size() == 0) begin
            report("result beat with nothing pending");
            return;
         end
         want = pending.pop_front();
         for (int k = 0; k < 9; k++)
            if (got.m[k] !== want.m[k])
               report($sformatf("m%0d%0d got %0d want %0d", k / 3, k % 3,
                                got.m[k], want.m[k]));
      endtask
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic signed [15:0] req_yaw_angle = 0;
   logic signed [15:0] req_pitch_angle = 0;
   logic signed [15:0] req_roll_angle = 0;
   logic               rsp_valid;
   logic               rsp_stall = 1;
   logic signed [15:0] rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12;
   logic signed [15:0] rsp_m20, rsp_m21, rsp_m22;

   matrix_scoreboard board = new();
   bit   no_idle = 0;
   bit   sending_done = 0;
   int   cycles = 0;

   euler_to_rotation_matrix dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Note accepted beats on both sides.
   always @(posedge clock) begin
      matrix_type got;
      if (!reset && req_valid && !req_stall)
         board.note_angles(req_yaw_angle, req_pitch_angle, req_roll_angle);
      if (!reset && rsp_valid && !rsp_stall) begin
         got.m = '{rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12,
                   rsp_m20, rsp_m21, rsp_m22};
         board.check_matrix(got);
      end
   end

   // Receiver: random stall, one long hold-off early on.
   initial begin
      int hold;
      @(posedge clock iff !reset);
      repeat (30) @(posedge clock);
      rsp_stall <= 1;
      for (hold = 0; hold < 200; hold++) @(posedge clock);
      forever begin
         rsp_stall <= !no_idle && ($urandom_range(99) < 32);
         @(posedge clock);
      end
   end

   task automatic send_beat(logic signed [15:0] yaw, logic signed [15:0] pitch,
                            logic signed [15:0] roll);
      while (!no_idle && $urandom_range(99) < 32) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid       <= 1;
      req_yaw_angle   <= yaw;
      req_pitch_angle <= pitch;
      req_roll_angle  <= roll;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_angle();
      logic signed [15:0] corners [10] = '{-32768, 32767, 0, -1, 1, 16384, -16384,
                                           16383, -16385, 8192};
      if ($urandom_range(9) == 0) return corners[$urandom_range(9)];
      return 16'($urandom());
   endfunction

   initial begin
      logic signed [15:0] edge_angles [9] = '{-32768, 32767, 0, -1, 1, 16384, -16384,
                                              16383, -16385};
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Extremes, quarter-turn fold boundaries and the minus-pi fold.
      foreach (edge_angles[k])
         send_beat(edge_angles[k], edge_angles[(k + 3) % 9], edge_angles[(k + 6) % 9]);
      send_beat(-32768, -32768, -32768);
      send_beat(16'h5555, 16'hAAAA, 16'h7FFF);
      send_beat(16'hAAAA, 16'h5555, 16'h8001);
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         no_idle = (n >= 600 && n < 900);
         send_beat(pick_angle(), pick_angle(), pick_angle());
      end
      req_valid <= 0;
      sending_done = 1;
   end

   initial begin
      wait (sending_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
